// File: src/spf_pkg.sv
// shared types, codes and crc helper for the servo ping frame engine
// no dependencies; imported by every module of the block
`default_nettype none

package spf_pkg;

	// input item kinds carried on the slave tuser
	typedef enum logic [1:0] {
		KIND_SEND    = 2'd0,
		KIND_RX      = 2'd1,
		KIND_TIMEOUT = 2'd2
	} in_kind_t;

	// result kinds carried on the master tuser
	typedef enum logic [1:0] {
		RES_TX      = 2'd0,
		RES_REPLY   = 2'd1,
		RES_TIMEOUT = 2'd2
	} res_kind_t;

	// work handed from the front part to the back part
	typedef enum logic [1:0] {
		CMD_PING    = 2'd0,
		CMD_REPLY   = 2'd1,
		CMD_TIMEOUT = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  id;
		logic [15:0] model;
		logic [7:0]  fw;
		logic        ok;
	} spf_cmd_t;

	// reply length default and fixed capture positions
	localparam int REPLY_LENGTH_DEF = 14;
	localparam logic [3:0] POS_MODEL_LO = 4'd9;
	localparam logic [3:0] POS_MODEL_HI = 4'd10;
	localparam logic [3:0] POS_FW       = 4'd11;

	// ping frame layout
	localparam logic [7:0] HDR_FF     = 8'hFF;
	localparam logic [7:0] HDR_FD     = 8'hFD;
	localparam logic [7:0] BYTE_ZERO  = 8'h00;
	localparam logic [7:0] PING_LEN   = 8'h03;
	localparam logic [7:0] INSTR_PING = 8'h01;
	localparam logic [3:0] FRAME_CRC_LO = 4'd8;
	localparam logic [3:0] FRAME_LAST   = 4'd9;

	localparam logic [15:0] CRC_POLY = 16'h8005;

	// command queue depth between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// one byte of crc-16, msb first, init and final xor handled by caller
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: src/servo_ping_frame_engine.sv
// top level of the servo ping frame engine: front, command queue, back
// depends on spf_pkg, spf_front, spf_queue, spf_back
`default_nettype none

// Ping engine for a packet servo bus with CRC-16 (poly 0x8005, init 0).
// A send transaction (tuser 0) yields the 10-byte ping frame, one byte per
// cycle while the output is ready, tlast on the final byte. Received bytes
// (tuser 1) are counted up to REPLY_LENGTH; the last one yields a single
// reply result with model number, firmware and crc_ok. A timeout (tuser 2)
// while waiting yields a timed-out result; bytes and timeouts while idle
// are dropped. The input side takes one transaction per cycle while the
// 4-entry command queue has room; the back end drains it, a ping giving one
// output per frame byte (the frame crc being built byte by byte as it goes
// out) and a reply or timeout a single result, so a stream of received
// bytes runs at one per cycle while the queue has room.
module servo_ping_frame_engine
	import spf_pkg::*;
#(
	parameter int REPLY_LENGTH = REPLY_LENGTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // servo_id, rx_byte
	input  wire logic [1:0]  s_axis_tuser,  // kind
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata,  // tx_byte, reply_id, model_number,
	                                        // firmware, crc_ok, zero pad
	output logic [1:0]       m_axis_tuser,  // result_kind
	output logic             m_axis_tlast
);

	logic            q_full;
	logic            q_empty;
	logic            push;
	logic            pop;
	spf_cmd_t        push_cmd;
	spf_cmd_t        head;
	logic [QPTR_W:0] q_count;

	logic [7:0]  tx_byte;
	logic [7:0]  reply_id;
	logic [15:0] model_number;
	logic [7:0]  fw_rev;
	logic        crc_ok;

	spf_front #(
		.REPLY_LENGTH(REPLY_LENGTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_kind  (s_axis_tuser),
		.in_id    (s_axis_tdata[7:0]),
		.in_rx    (s_axis_tdata[15:8]),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	spf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full),
		.count    (q_count)
	);

	spf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_kind  (m_axis_tuser),
		.out_last  (m_axis_tlast),
		.out_tx    (tx_byte),
		.out_id    (reply_id),
		.out_model (model_number),
		.out_fw    (fw_rev),
		.out_ok    (crc_ok)
	);

	// result packing
	assign m_axis_tdata = {7'd0, crc_ok, fw_rev, model_number, reply_id, tx_byte};

	// a send transaction always leaves work in the queue
	a_send_queued: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_SEND)
		|=> (q_count != '0))
		else $error("send transaction did not reach the command queue");

	// end of frame only on transmit bytes, which carry no reply id
	a_last_on_tx: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast
		|-> (m_axis_tuser == RES_TX) && (m_axis_tdata[15:8] == 8'd0))
		else $error("tlast on a non-transmit result");

	// reply and timeout results carry no transmit byte
	a_no_tx_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != RES_TX)
		|-> (m_axis_tdata[7:0] == 8'd0) && !m_axis_tlast)
		else $error("transmit byte set on a reply or timeout result");

	// a full queue holds off the input side
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(q_count == (QPTR_W + 1)'(QUEUE_DEPTH)) |-> !s_axis_tready)
		else $error("input accepted with the command queue full");

endmodule

`default_nettype wire

// File: src/spf_front.sv
// front part: accepts items, tracks the reply wait and crc, issues commands
// depends on spf_pkg
`default_nettype none

module spf_front
	import spf_pkg::*;
#(
	parameter int REPLY_LENGTH = REPLY_LENGTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] in_kind,
	input  wire logic [7:0] in_id,
	input  wire logic [7:0] in_rx,
	input  wire logic       q_full,
	output logic            push,
	output spf_cmd_t        push_cmd
);

	localparam logic [3:0] LAST_POS = 4'(REPLY_LENGTH - 1);
	localparam logic [3:0] CRC_POS  = 4'(REPLY_LENGTH - 2);

	logic        waiting_q;
	logic [3:0]  count_q;
	logic [15:0] crc_q;
	logic [7:0]  id_q;
	logic [7:0]  model_lo_q;
	logic [7:0]  model_hi_q;
	logic [7:0]  fw_q;
	logic [7:0]  crc_lo_q;

	in_kind_t    kind;
	logic        accept;
	logic        rx_final;
	logic [7:0]  model_lo_n;
	logic [7:0]  model_hi_n;
	logic [7:0]  fw_n;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign kind     = in_kind_t'(in_kind);
	assign rx_final = (count_q == LAST_POS);

	// captured fields including the byte of this transaction
	assign model_lo_n = (count_q == POS_MODEL_LO) ? in_rx : model_lo_q;
	assign model_hi_n = (count_q == POS_MODEL_HI) ? in_rx : model_hi_q;
	assign fw_n       = (count_q == POS_FW) ? in_rx : fw_q;

	// command issue
	always_comb begin
		push          = 1'b0;
		push_cmd      = '0;
		push_cmd.kind = CMD_PING;
		push_cmd.id   = id_q;
		case (kind)
			KIND_SEND: begin
				push        = accept;
				push_cmd.id = in_id;
			end
			KIND_RX: begin
				push           = accept && waiting_q && rx_final;
				push_cmd.kind  = CMD_REPLY;
				push_cmd.model = {model_hi_n, model_lo_n};
				push_cmd.fw    = fw_n;
				push_cmd.ok    = ({in_rx, crc_lo_q} == crc_q);
			end
			KIND_TIMEOUT: begin
				push          = accept && waiting_q;
				push_cmd.kind = CMD_TIMEOUT;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// wait state, byte count and reply capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q  <= 1'b0;
			count_q    <= '0;
			crc_q      <= '0;
			id_q       <= '0;
			model_lo_q <= '0;
			model_hi_q <= '0;
			fw_q       <= '0;
			crc_lo_q   <= '0;
		end else if (accept) begin
			case (kind)
				KIND_SEND: begin
					waiting_q  <= 1'b1;
					count_q    <= '0;
					crc_q      <= '0;
					id_q       <= in_id;
					model_lo_q <= '0;
					model_hi_q <= '0;
					fw_q       <= '0;
					crc_lo_q   <= '0;
				end
				KIND_RX: begin
					if (waiting_q) begin
						if (count_q < CRC_POS) begin
							crc_q <= crc_byte(crc_q, in_rx);
						end
						if (count_q == CRC_POS) begin
							crc_lo_q <= in_rx;
						end
						model_lo_q <= model_lo_n;
						model_hi_q <= model_hi_n;
						fw_q       <= fw_n;
						if (rx_final) begin
							waiting_q <= 1'b0;
							count_q   <= '0;
						end else begin
							count_q <= count_q + 4'd1;
						end
					end
				end
				KIND_TIMEOUT: begin
					if (waiting_q) begin
						waiting_q <= 1'b0;
						count_q   <= '0;
					end
				end
				default: begin
					waiting_q <= waiting_q;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: src/spf_queue.sv
// command queue between the front and back parts, fill-count fifo
// depends on spf_pkg
`default_nettype none

module spf_queue
	import spf_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  spf_cmd_t       push_cmd,
	input  wire logic      pop,
	output spf_cmd_t       head,
	output logic           empty,
	output logic           full,
	output logic [QPTR_W:0] count
);

	spf_cmd_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign count   = count_q;
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QPTR_W + 1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QPTR_W + 1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: src/spf_back.sv
// back part: expands ping commands into frame bytes, emits reply/timeout results
// depends on spf_pkg
`default_nettype none

module spf_back
	import spf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  spf_cmd_t         head,
	input  wire logic        empty,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       out_kind,
	output logic             out_last,
	output logic [7:0]       out_tx,
	output logic [7:0]       out_id,
	output logic [15:0]      out_model,
	output logic [7:0]       out_fw,
	output logic             out_ok
);

	logic        valid_q;
	logic [1:0]  kind_q;
	logic        last_q;
	logic [7:0]  tx_q;
	logic [7:0]  id_q;
	logic [15:0] model_q;
	logic [7:0]  fw_q;
	logic        ok_q;
	logic [3:0]  idx_q;
	logic [15:0] crc_q;

	logic        advance;
	logic        emit;
	logic [7:0]  frame_byte;

	assign advance = !valid_q || out_ready;
	assign emit    = advance && !empty;
	assign pop     = emit && ((head.kind != CMD_PING) || (idx_q == FRAME_LAST));

	// current ping frame byte
	always_comb begin
		case (idx_q)
			4'd0, 4'd1: frame_byte = HDR_FF;
			4'd2:       frame_byte = HDR_FD;
			4'd3:       frame_byte = BYTE_ZERO;
			4'd4:       frame_byte = head.id;
			4'd5:       frame_byte = PING_LEN;
			4'd6:       frame_byte = BYTE_ZERO;
			4'd7:       frame_byte = INSTR_PING;
			4'd8:       frame_byte = crc_q[7:0];
			4'd9:       frame_byte = crc_q[15:8];
			default:    frame_byte = BYTE_ZERO;
		endcase
	end

	// output register and frame sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			kind_q  <= RES_TX;
			last_q  <= 1'b0;
			tx_q    <= '0;
			id_q    <= '0;
			model_q <= '0;
			fw_q    <= '0;
			ok_q    <= 1'b0;
			idx_q   <= '0;
			crc_q   <= '0;
		end else if (emit) begin
			valid_q <= 1'b1;
			case (head.kind)
				CMD_PING: begin
					kind_q  <= RES_TX;
					tx_q    <= frame_byte;
					last_q  <= (idx_q == FRAME_LAST);
					id_q    <= '0;
					model_q <= '0;
					fw_q    <= '0;
					ok_q    <= 1'b0;
					if (idx_q < FRAME_CRC_LO) begin
						crc_q <= crc_byte(crc_q, frame_byte);
					end
					if (idx_q == FRAME_LAST) begin
						idx_q <= '0;
						crc_q <= '0;
					end else begin
						idx_q <= idx_q + 4'd1;
					end
				end
				CMD_REPLY: begin
					kind_q  <= RES_REPLY;
					tx_q    <= '0;
					last_q  <= 1'b0;
					id_q    <= head.id;
					model_q <= head.model;
					fw_q    <= head.fw;
					ok_q    <= head.ok;
				end
				default: begin
					kind_q  <= RES_TIMEOUT;
					tx_q    <= '0;
					last_q  <= 1'b0;
					id_q    <= head.id;
					model_q <= '0;
					fw_q    <= '0;
					ok_q    <= 1'b0;
				end
			endcase
		end else if (advance) begin
			valid_q <= 1'b0;
		end
	end

	assign out_valid = valid_q;
	assign out_kind  = kind_q;
	assign out_last  = last_q;
	assign out_tx    = tx_q;
	assign out_id    = id_q;
	assign out_model = model_q;
	assign out_fw    = fw_q;
	assign out_ok    = ok_q;

endmodule

`default_nettype wire

// File: tb/sv/spf_link_checker.sv
`timescale 1ns / 1ps
// crc helper shared by stimulus and checking, plus the link checker that watches
// both stream channels of the servo ping frame engine; depends on spf_pkg

package spf_tb_crc_pkg;
	import spf_pkg::*;

	// crc-16 with poly 0x8005, msb first, one data bit per step
	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ data[i];
			c = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction
endpackage

module spf_link_checker
	import spf_pkg::*;
	import spf_tb_crc_pkg::*;
#(
	parameter int REPLY_LEN = REPLY_LENGTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // servo_id, rx_byte
	input  wire logic [1:0]  s_axis_tuser,   // kind
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [47:0] m_axis_tdata,   // tx_byte, reply_id, model_number,
	                                         // firmware, crc_ok, zero pad
	input  wire logic [1:0]  m_axis_tuser,   // result_kind
	input  wire logic        m_axis_tlast,
	output int               fail_count,
	output int               pending_count
);

	typedef struct packed {
		res_kind_t   kind;
		logic [7:0]  tx_byte;
		logic        last;
		logic [7:0]  reply_id;
		logic [15:0] model;
		logic [7:0]  fw;
		logic        crc_ok;
	} bus_result_t;

	// results the engine still owes, oldest first
	bus_result_t due_results[$];

	int mismatches = 0;
	int due_count  = 0;

	// engine state as seen from the ports
	logic        waiting;
	logic [3:0]  rx_pos;
	logic [15:0] reply_crc;
	logic [7:0]  ping_id;
	logic [7:0]  model_lo;
	logic [7:0]  model_hi;
	logic [7:0]  fw_byte;
	logic [7:0]  crc_lo_seen;

	assign fail_count    = mismatches;
	assign pending_count = due_count;

	task automatic check_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h got %h", $time, field, want, got);
			mismatches++;
		end
	endtask

	// advance the engine by one accepted input transaction
	task automatic ping_engine_step(input in_kind_t kind, input logic [7:0] id,
			input logic [7:0] rx);
		logic [7:0]  frame [10];
		logic [15:0] crc;
		logic [3:0]  pos;
		bus_result_t r;
		case (kind)
			KIND_SEND: begin
				frame[0] = HDR_FF;
				frame[1] = HDR_FF;
				frame[2] = HDR_FD;
				frame[3] = BYTE_ZERO;
				frame[4] = id;
				frame[5] = PING_LEN;
				frame[6] = BYTE_ZERO;
				frame[7] = INSTR_PING;
				crc = 16'h0000;
				for (int k = 0; k < FRAME_CRC_LO; k++) begin
					crc = crc16_step(crc, frame[k]);
				end
				frame[FRAME_CRC_LO] = crc[7:0];
				frame[FRAME_LAST]   = crc[15:8];
				for (int k = 0; k <= FRAME_LAST; k++) begin
					r = '0;
					r.kind = RES_TX;
					r.tx_byte = frame[k];
					r.last = (k == FRAME_LAST);
					due_results.push_back(r);
				end
				// a send drops any reply still in progress
				waiting     = 1'b1;
				rx_pos      = '0;
				reply_crc   = '0;
				ping_id     = id;
				model_lo    = '0;
				model_hi    = '0;
				fw_byte     = '0;
				crc_lo_seen = '0;
			end
			KIND_RX: begin
				if (waiting) begin
					pos = rx_pos;
					if (pos < REPLY_LEN - 2) begin
						reply_crc = crc16_step(reply_crc, rx);
					end
					if (pos == POS_MODEL_LO) begin
						model_lo = rx;
					end
					if (pos == POS_MODEL_HI) begin
						model_hi = rx;
					end
					if (pos == POS_FW) begin
						fw_byte = rx;
					end
					if (pos == REPLY_LEN - 2) begin
						crc_lo_seen = rx;
					end
					if (pos + 1 >= REPLY_LEN) begin
						r = '0;
						r.kind = RES_REPLY;
						r.reply_id = ping_id;
						r.model = {model_hi, model_lo};
						r.fw = fw_byte;
						r.crc_ok = ({rx, crc_lo_seen} == reply_crc);
						due_results.push_back(r);
						waiting = 1'b0;
						rx_pos  = '0;
					end else begin
						rx_pos = pos + 4'd1;
					end
				end
			end
			KIND_TIMEOUT: begin
				if (waiting) begin
					r = '0;
					r.kind = RES_TIMEOUT;
					r.reply_id = ping_id;
					due_results.push_back(r);
					waiting = 1'b0;
					rx_pos  = '0;
				end
			end
			default: begin
			end
		endcase
	endtask

	// output transactions are compared before this edge's input is applied
	always @(posedge clk or negedge arst_n) begin
		bus_result_t got;
		bus_result_t want;
		if (!arst_n) begin
			waiting     = 1'b0;
			rx_pos      = '0;
			reply_crc   = '0;
			ping_id     = '0;
			model_lo    = '0;
			model_hi    = '0;
			fw_byte     = '0;
			crc_lo_seen = '0;
			due_results.delete();
			due_count = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind     = res_kind_t'(m_axis_tuser);
				got.tx_byte  = m_axis_tdata[7:0];
				got.last     = m_axis_tlast;
				got.reply_id = m_axis_tdata[15:8];
				got.model    = m_axis_tdata[31:16];
				got.fw       = m_axis_tdata[39:32];
				got.crc_ok   = m_axis_tdata[40];
				if (due_results.size() == 0) begin
					$display("%0t: result expected none got kind %0d data %h last %b",
						$time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					check_field("result_kind", want.kind, got.kind);
					check_field("tx_byte", want.tx_byte, got.tx_byte);
					check_field("last", want.last, got.last);
					check_field("reply_id", want.reply_id, got.reply_id);
					check_field("model_number", want.model, got.model);
					check_field("fw_rev", want.fw, got.fw);
					check_field("crc_ok", want.crc_ok, got.crc_ok);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				ping_engine_step(in_kind_t'(s_axis_tuser), s_axis_tdata[7:0],
					s_axis_tdata[15:8]);
			end
			due_count = due_results.size();
		end
	end

endmodule

// File: tb/sv/tb_servo_ping_frame_engine.sv
`timescale 1ns / 1ps
// top of the servo ping frame engine testbench: clock, reset, stimulus and verdict
// depends on spf_pkg, spf_tb_crc_pkg, spf_link_checker and the engine rtl

module tb_servo_ping_frame_engine;
	import spf_pkg::*;
	import spf_tb_crc_pkg::*;

	localparam int         CLK_HALF_NS  = 6;
	localparam int         WORK_TARGET  = 220;
	localparam int         DRAIN_CYCLES = 40;
	localparam longint     LIMIT_NS     = 64'd2_000_000;
	localparam logic [1:0] KIND_UNUSED  = 2'd3;
	// status reply layout bytes
	localparam logic [7:0] STATUS_LEN   = 8'h07;
	localparam logic [7:0] INSTR_STATUS = 8'h55;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	int fail_count;
	int pending_count;
	int work_items = 0;
	bit src_calm   = 1'b0;

	servo_ping_frame_engine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	spf_link_checker link_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	// clock
	always begin
		clk = 1'b1;
		#(CLK_HALF_NS);
		clk = 1'b0;
		#(CLK_HALF_NS);
	end

	// one input transaction, entered and left at a falling edge
	task automatic push_item(input logic [1:0] kind, input logic [7:0] id,
			input logic [7:0] data, input bit counted);
		int gap;
		if ($urandom_range(0, 15) == 0) begin
			src_calm = !src_calm;
		end
		gap = src_calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {data, id};
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		@(negedge clk);
		if (counted) begin
			work_items++;
		end
	endtask

	// status reply bytes for a ping, optionally damaged or cut short
	task automatic reply_bytes(input logic [7:0] id, input bit realistic,
			input bit corrupt, input int cut_at);
		logic [7:0]  body [14];
		logic [15:0] crc;
		int          hit;
		for (int k = 0; k < 12; k++) begin
			body[k] = 8'($urandom_range(0, 255));
		end
		if (realistic) begin
			body[0] = HDR_FF;
			body[1] = HDR_FF;
			body[2] = HDR_FD;
			body[3] = BYTE_ZERO;
			body[4] = id;
			body[5] = STATUS_LEN;
			body[6] = BYTE_ZERO;
			body[7] = INSTR_STATUS;
			body[8] = BYTE_ZERO;
		end
		crc = 16'h0000;
		for (int k = 0; k < 12; k++) begin
			crc = crc16_step(crc, body[k]);
		end
		body[12] = crc[7:0];
		body[13] = crc[15:8];
		if (corrupt) begin
			hit = $urandom_range(0, 13);
			body[hit] = body[hit] ^ 8'($urandom_range(1, 255));
		end
		for (int k = 0; k < cut_at; k++) begin
			// stray unused kind inside the reply
			if ($urandom_range(0, 15) == 0) begin
				push_item(KIND_UNUSED, 8'($urandom), 8'($urandom), 1'b0);
			end
			push_item(KIND_RX, 8'($urandom), body[k], 1'b1);
		end
	endtask

	// ready side: random stall before each result, with quiet stretches
	initial begin : sink_side
		int stall;
		bit calm;
		calm = 1'b0;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0) begin
				calm = !calm;
			end
			stall = calm ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do begin
				@(posedge clk);
			end while (!(m_axis_tvalid && m_axis_tready));
			@(negedge clk);
		end
	end

	// run limit
	initial begin
		#(LIMIT_NS);
		$display("servo_ping_frame_engine: mismatch");
		$finish;
	end

	// stimulus and verdict
	initial begin
		logic [7:0] id;
		int         sel;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: idle noise, timeout, send over a pending wait, clean reply
		push_item(KIND_RX, 8'h00, 8'hFF, 1'b0);
		push_item(KIND_TIMEOUT, 8'hFF, 8'h00, 1'b0);
		push_item(KIND_UNUSED, 8'hFF, 8'hFF, 1'b0);
		push_item(KIND_SEND, 8'h00, 8'h00, 1'b1);
		push_item(KIND_TIMEOUT, 8'h00, 8'h00, 1'b1);
		push_item(KIND_SEND, 8'hFF, 8'hFF, 1'b1);
		push_item(KIND_SEND, 8'hFE, 8'h00, 1'b1);
		push_item(KIND_UNUSED, 8'h00, 8'h00, 1'b0);
		reply_bytes(8'hFE, 1'b1, 1'b0, 14);
		push_item(KIND_RX, 8'hFE, 8'hFF, 1'b0);

		// random ping and reply sequences with noise between them
		while (work_items < WORK_TARGET) begin
			if ($urandom_range(0, 9) == 0) begin
				sel = $urandom_range(0, 2);
				case (sel)
					0: push_item(KIND_RX, 8'($urandom), 8'($urandom), 1'b0);
					1: push_item(KIND_TIMEOUT, 8'($urandom), 8'($urandom), 1'b0);
					default: push_item(KIND_UNUSED, 8'($urandom), 8'($urandom), 1'b0);
				endcase
			end
			sel = $urandom_range(0, 15);
			if (sel == 0) begin
				id = 8'hFE;
			end else if (sel == 1) begin
				id = 8'h00;
			end else if (sel == 2) begin
				id = 8'hFF;
			end else begin
				id = 8'($urandom);
			end
			push_item(KIND_SEND, id, 8'($urandom), 1'b1);
			sel = $urandom_range(0, 9);
			if (sel < 6) begin
				reply_bytes(id, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0, 14);
				if ($urandom_range(0, 4) == 0) begin
					push_item(KIND_RX, 8'($urandom), 8'($urandom), 1'b0);
				end
			end else if (sel < 8) begin
				reply_bytes(id, 1'($urandom_range(0, 1)), 1'b0, $urandom_range(0, 13));
				push_item(KIND_TIMEOUT, 8'($urandom), 8'($urandom), 1'b1);
			end else begin
				// left waiting: the next send drops this reply
				reply_bytes(id, 1'($urandom_range(0, 1)), 1'b0, $urandom_range(0, 13));
			end
		end
		s_axis_tvalid <= 1'b0;

		// drain, then give stray results a chance to show up
		while (pending_count != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("servo_ping_frame_engine: match");
		end else begin
			$display("servo_ping_frame_engine: mismatch");
		end
		$finish;
	end

endmodule
